>>> rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the serial setpoint command parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int LINE_MAX_DEF = 24;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_UC_P  = 8'h50;
	localparam logic [7:0] CH_UC_V  = 8'h56;

	localparam logic [15:0] VOLT_RESET = 16'd3300;
	localparam logic [15:0] AMP_RESET  = 16'd500;
	localparam logic [7:0]  PWR_RESET  = 8'd0;

	typedef enum logic [2:0] {
		ST_VOLT    = 3'd0,
		ST_AMP     = 3'd1,
		ST_POWER   = 3'd2,
		ST_BAD     = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SPACE  = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// running summary of the current line
	typedef struct packed {
		logic        kept_nz;
		logic [7:0]  first_byte;
		logic        second_semi;
		logic [7:0]  last_byte;
		logic [1:0]  semi_count;
		logic        negative;
		logic [15:0] accum;
	} line_info_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] value;
		logic        set_volt;
		logic        set_amp;
		logic        set_pwr;
	} eval_res_t;

endpackage

>>> rtl/ssp_line.sv
// ----------------------------------------------------------------------------
// ssp_line
// Line tracker: keeps the first and last bytes, semicolon counts and the
// running atoi state of the number after the first semicolon.
// ----------------------------------------------------------------------------
module ssp_line #(
	parameter int LINE_MAX = ssp_pkg::LINE_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   eol,
	input  logic [7:0]             rx_byte,
	output ssp_pkg::line_info_t    info
);
	import ssp_pkg::*;

	localparam int CntW = $clog2(LINE_MAX + 1);

	logic [CntW-1:0] kept_q;
	logic [7:0]      first_q;
	logic            second_semi_q;
	logic [7:0]      last_q;
	logic [1:0]      semi_cnt_q;
	phase_t          phase_q;
	logic            neg_q;
	logic [15:0]     accum_q;

	logic            keep;
	logic            is_semi;
	logic            is_blank;
	logic            is_digit;
	phase_t          phase_d;
	logic            neg_d;
	logic [15:0]     accum_d;

	assign keep     = step && !eol && (kept_q < CntW'(LINE_MAX));
	assign is_semi  = rx_byte == CH_SEMI;
	assign is_blank = rx_byte == CH_SPACE || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
	assign is_digit = rx_byte >= CH_ZERO && rx_byte <= CH_NINE;

	// number state after one byte at position one or later
	always_comb begin
		logic sign_taken;
		sign_taken = 1'b0;
		phase_d    = phase_q;
		neg_d      = neg_q;
		accum_d    = accum_q;
		if (phase_q == PH_SPACE) begin
			if (is_blank) begin
				sign_taken = 1'b1;
			end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
				neg_d      = rx_byte == CH_MINUS;
				phase_d    = PH_DIGITS;
				sign_taken = 1'b1;
			end else begin
				phase_d = PH_DIGITS;
			end
		end
		if (phase_d == PH_DIGITS && !sign_taken) begin
			if (is_digit) begin
				accum_d = (accum_q << 3) + (accum_q << 1) + {12'd0, rx_byte[3:0]};
			end else begin
				phase_d = PH_DONE;
			end
		end
		if (is_semi && phase_d == PH_IDLE) begin
			phase_d = PH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q        <= '0;
			first_q       <= '0;
			second_semi_q <= 1'b0;
			last_q        <= '0;
			semi_cnt_q    <= '0;
			phase_q       <= PH_IDLE;
			neg_q         <= 1'b0;
			accum_q       <= '0;
		end else if (step && eol) begin
			kept_q        <= '0;
			first_q       <= '0;
			second_semi_q <= 1'b0;
			last_q        <= '0;
			semi_cnt_q    <= '0;
			phase_q       <= PH_IDLE;
			neg_q         <= 1'b0;
			accum_q       <= '0;
		end else if (keep) begin
			kept_q <= kept_q + CntW'(1);
			last_q <= rx_byte;
			if (kept_q == '0) begin
				first_q <= rx_byte;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				accum_q <= accum_d;
				if (is_semi) begin
					if (kept_q == CntW'(1)) begin
						second_semi_q <= 1'b1;
					end
					if (semi_cnt_q != 2'd2) begin
						semi_cnt_q <= semi_cnt_q + 2'd1;
					end
				end
			end
		end
	end

	assign info.kept_nz     = kept_q != '0;
	assign info.first_byte  = first_q;
	assign info.second_semi = second_semi_q;
	assign info.last_byte   = last_q;
	assign info.semi_count  = semi_cnt_q;
	assign info.negative    = neg_q;
	assign info.accum       = accum_q;

endmodule

>>> rtl/ssp_eval.sv
// ----------------------------------------------------------------------------
// ssp_eval
// Line check at line end: classifies the command and forms the value.
// ----------------------------------------------------------------------------
module ssp_eval (
	input  ssp_pkg::line_info_t info,
	output ssp_pkg::eval_res_t  res
);
	import ssp_pkg::*;

	logic [15:0] num;

	assign num = info.negative ? (16'd0 - info.accum) : info.accum;

	always_comb begin
		res.status   = ST_UNKNOWN;
		res.value    = '0;
		res.set_volt = 1'b0;
		res.set_amp  = 1'b0;
		res.set_pwr  = 1'b0;
		if (!info.kept_nz || info.first_byte < CH_UC_A || info.first_byte > CH_UC_Z ||
				info.last_byte != CH_HASH) begin
			res.status = ST_UNKNOWN;
		end else if (!info.second_semi || info.semi_count != 2'd1) begin
			res.status = ST_BAD;
		end else begin
			case (info.first_byte)
				CH_UC_V: begin
					res.status   = ST_VOLT;
					res.value    = num;
					res.set_volt = 1'b1;
				end
				CH_UC_A: begin
					res.status  = ST_AMP;
					res.value   = num;
					res.set_amp = 1'b1;
				end
				CH_UC_P: begin
					res.status  = ST_POWER;
					res.value   = {8'd0, num[7:0]};
					res.set_pwr = 1'b1;
				end
				default: begin
					res.status = ST_BAD;
				end
			endcase
		end
	end

endmodule

>>> rtl/serial_setpoint_command_parser_top.sv
// Throughput: one byte per cycle; the only stall is a line end meeting a held result.
// Every byte goes through an input register into the line tracker; a line end
// loads the checker's result and the setpoints into the result register.
// Reset: line state cleared; setpoints 3300 mV, 500 mA, power 0; no result pending.
// ----------------------------------------------------------------------------
// serial_setpoint_command_parser_top
// Byte-wide command line parser that updates voltage, current and power setpoints.
// ----------------------------------------------------------------------------
module serial_setpoint_command_parser_top #(
	parameter int LINE_MAX = ssp_pkg::LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  status,
	output logic [15:0] value,
	output logic [15:0] voltage_mv,
	output logic [15:0] current_ma,
	output logic [7:0]  power_level
);
	import ssp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eol_s1;
	logic        adv;
	line_info_t  info;
	eval_res_t   res;

	logic [15:0] volt_q;
	logic [15:0] amp_q;
	logic [7:0]  pwr_q;
	logic [15:0] volt_d;
	logic [15:0] amp_d;
	logic [7:0]  pwr_d;

	logic        res_valid_q;
	status_t     status_q;
	logic [15:0] value_q;
	logic [15:0] volt_out_q;
	logic [15:0] amp_out_q;
	logic [7:0]  pwr_out_q;

	assign eol_s1   = byte_s1 == CH_CR || byte_s1 == CH_LF;
	// only a line end needs room in the result register
	assign adv      = valid_s1 && (!eol_s1 || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	ssp_line #(
		.LINE_MAX (LINE_MAX)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.eol     (eol_s1),
		.rx_byte (byte_s1),
		.info    (info)
	);

	ssp_eval u_eval (
		.info (info),
		.res  (res)
	);

	assign volt_d = res.set_volt ? res.value : volt_q;
	assign amp_d  = res.set_amp ? res.value : amp_q;
	assign pwr_d  = res.set_pwr ? res.value[7:0] : pwr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q <= VOLT_RESET;
			amp_q  <= AMP_RESET;
			pwr_q  <= PWR_RESET;
		end else if (adv && eol_s1) begin
			volt_q <= volt_d;
			amp_q  <= amp_d;
			pwr_q  <= pwr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && eol_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eol_s1) begin
			status_q   <= res.status;
			value_q    <= res.value;
			volt_out_q <= volt_d;
			amp_out_q  <= amp_d;
			pwr_out_q  <= pwr_d;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign value       = value_q;
	assign voltage_mv  = volt_out_q;
	assign current_ma  = amp_out_q;
	assign power_level = pwr_out_q;

endmodule

>>> rtl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks of the command parser, bound to the top level.
// ----------------------------------------------------------------------------
module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [15:0] value,
	input logic [15:0] voltage_mv,
	input logic [15:0] current_ma,
	input logic [7:0]  power_level
);
	import ssp_pkg::*;

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(value) &&
			$stable(voltage_mv) && $stable(current_ma) && $stable(power_level))
		else $error("result changed while stalled");

	// a voltage or current transaction shows the new setpoint
	a_va: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_VOLT || status == ST_AMP) |->
			value == ((status == ST_VOLT) ? voltage_mv : current_ma))
		else $error("setpoint does not match value");

	a_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_POWER |-> value == {8'd0, power_level})
		else $error("power setting does not match value");

	// rejected lines report zero
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_BAD || status == ST_UNKNOWN) |-> value == 16'd0)
		else $error("rejected line with nonzero value");

endmodule

bind serial_setpoint_command_parser_top ssp_checker u_ssp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_ready   (res_ready),
	.status      (status),
	.value       (value),
	.voltage_mv  (voltage_mv),
	.current_ma  (current_ma),
	.power_level (power_level)
);
